/* sv/life_like_automaton_step_core_defines.svh */
// Assertion macros shared by the life-like automaton step core.
`ifndef LIFE_LIKE_AUTOMATON_STEP_CORE_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_STEP_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LLA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LLA_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `LLA_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define LLA_ASSERT(lbl, clk, rstn, prop, msg)
`define LLA_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* sv/lla_pkg.sv */
// Shared types and constants of the life-like automaton step core.
package lla_pkg;

  localparam int unsigned MaxWidthDef  = 128;
  localparam int unsigned MaxHeightDef = 128;
  localparam int unsigned MaskW        = 9;
  localparam int unsigned DimW         = 8;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    RegBirthMask    = 2'd0,
    RegSurvivalMask = 2'd1,
    RegGridWidth    = 2'd2,
    RegGridHeight   = 2'd3
  } cfg_reg_e;

  localparam logic [MaskW-1:0] BirthMaskRst    = 9'd8;
  localparam logic [MaskW-1:0] SurvivalMaskRst = 9'd12;
  localparam logic [DimW-1:0]  GridWidthRst    = 8'd128;
  localparam logic [DimW-1:0]  GridHeightRst   = 8'd128;

  // One classified cell on its way from the front part to the back part.
  typedef struct packed {
    logic above;
    logic cur;
    logic alive;
    logic col_zero;
    logic row_zero;
    logic end_of_row;
    logic flush;
  } cell_rec_t;

  typedef struct packed {
    logic next_alive;
    logic last_of_frame;
  } result_t;

  typedef struct packed {
    logic [MaskW-1:0] birth;
    logic [MaskW-1:0] survival;
  } rule_t;

endpackage

/* sv/lla_fifo.sv */
// Small register-based queue used between the core's parts and at its output.
`include "life_like_automaton_step_core_defines.svh"

module lla_fifo #(
  parameter int unsigned Width = $bits(lla_pkg::result_t),
  parameter int unsigned Depth = lla_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);

  logic [Width-1:0] store_q [Depth];
  logic [PtrW:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW:0]    rd_ptr_q, rd_ptr_d;

  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign full_o  = (wr_ptr_q[PtrW] != rd_ptr_q[PtrW]) &&
                   (wr_ptr_q[PtrW-1:0] == rd_ptr_q[PtrW-1:0]);
  assign data_o  = store_q[rd_ptr_q[PtrW-1:0]];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_i && !full_o) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i && !empty_o) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      store_q[wr_ptr_q[PtrW-1:0]] <= data_i;
    end
  end

  `LLA_ASSERT_NEVER(a_fifo_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `LLA_ASSERT_NEVER(a_fifo_full_xor_empty, clk_i, rst_ni, full_o && empty_o, "queue full and empty")

endmodule

/* sv/lla_front.sv */
// Front part: raster position tracking, line store access and cell classification.
`include "life_like_automaton_step_core_defines.svh"

module lla_front #(
  parameter int unsigned MAX_WIDTH  = lla_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = lla_pkg::MaxHeightDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  logic                      mode_i,
  input  logic                      cell_alive_i,
  output logic                      full_o,
  input  logic [lla_pkg::DimW-1:0]  grid_width_i,
  input  logic [lla_pkg::DimW-1:0]  grid_height_i,
  output lla_pkg::cell_rec_t        rec_o,
  output logic                      rec_push_o,
  input  logic                      rec_full_i
);

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned RowW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned WCmpW = ($clog2(MAX_WIDTH + 1) > lla_pkg::DimW) ?
                                  $clog2(MAX_WIDTH + 1) : lla_pkg::DimW;
  localparam int unsigned HCmpW = ($clog2(MAX_HEIGHT + 1) > lla_pkg::DimW) ?
                                  $clog2(MAX_HEIGHT + 1) : lla_pkg::DimW;
  localparam logic [WCmpW-1:0] MaxWVal = WCmpW'(MAX_WIDTH);
  localparam logic [HCmpW-1:0] MaxHVal = HCmpW'(MAX_HEIGHT);
  localparam logic [ColW-1:0]  LastCol = ColW'(MAX_WIDTH - 1);

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             clr_q, clr_d;
  logic [ColW-1:0]  clr_cnt_q, clr_cnt_d;
  logic             b_valid_q, b_valid_d;

  logic [ColW-1:0]  b_col_q;
  logic             b_cell_q;
  logic             b_col_zero_q;
  logic             b_row_zero_q;
  logic             b_end_q;
  logic             b_flush_q;
  logic [1:0]       rd_q;

  // Each entry holds the row above in bit 0 and the current row in bit 1.
  logic [1:0]       line_q [MAX_WIDTH];

  logic [WCmpW-1:0] w_raw, w_eff;
  logic [HCmpW-1:0] h_raw, h_eff;
  logic             accept;
  logic             b_fire;
  logic             end_of_row;
  logic             flush_row;
  logic             cell_now;

  always_comb begin
    w_raw = WCmpW'(grid_width_i);
    h_raw = HCmpW'(grid_height_i);
    if (w_raw < WCmpW'(2)) begin
      w_eff = WCmpW'(2);
    end else if (w_raw > MaxWVal) begin
      w_eff = MaxWVal;
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < HCmpW'(2)) begin
      h_eff = HCmpW'(2);
    end else if (h_raw > MaxHVal) begin
      h_eff = MaxHVal;
    end else begin
      h_eff = h_raw;
    end
  end

  assign full_o     = clr_q | (b_valid_q & rec_full_i);
  assign accept     = push_i & ~full_o;
  assign b_fire     = b_valid_q & ~rec_full_i;
  assign end_of_row = WCmpW'(col_q) >= (w_eff - WCmpW'(1));
  assign flush_row  = HCmpW'(row_q) >= h_eff;
  assign cell_now   = cell_alive_i & ~mode_i & ~flush_row;

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    b_valid_d = b_valid_q & rec_full_i;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      clr_d     = (clr_cnt_q != LastCol);
    end
    if (accept) begin
      b_valid_d = 1'b1;
      if (end_of_row) begin
        col_d = '0;
        row_d = flush_row ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      b_valid_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_col_q      <= col_q;
      b_cell_q     <= cell_now;
      b_col_zero_q <= (col_q == '0);
      b_row_zero_q <= (row_q == '0);
      b_end_q      <= end_of_row;
      b_flush_q    <= flush_row;
    end
  end

  // Line store: read when the item is taken, written back when it leaves.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      line_q[clr_cnt_q] <= '0;
    end else if (b_fire) begin
      line_q[b_col_q] <= {b_cell_q, b_row_zero_q ? 1'b0 : rd_q[1]};
    end
    if (accept) begin
      rd_q <= line_q[col_q];
    end
  end

  always_comb begin
    rec_o.above      = rd_q[0];
    rec_o.cur        = rd_q[1];
    rec_o.alive      = b_cell_q;
    rec_o.col_zero   = b_col_zero_q;
    rec_o.row_zero   = b_row_zero_q;
    rec_o.end_of_row = b_end_q;
    rec_o.flush      = b_flush_q;
  end
  assign rec_push_o = b_fire;

  `LLA_ASSERT(a_front_row_end_wraps, clk_i, rst_ni, accept && end_of_row |=> col_q == '0, "column did not wrap at row end")
  `LLA_ASSERT(a_front_stall_holds, clk_i, rst_ni, b_valid_q && rec_full_i |=> b_valid_q && $stable(b_col_q), "stalled cell lost")

endmodule

/* sv/lla_back.sv */
// Back part: 3x3 window, neighbor count, rule lookup and result sequencing.
`include "life_like_automaton_step_core_defines.svh"

module lla_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lla_pkg::rule_t      rule_i,
  input  lla_pkg::cell_rec_t  rec_i,
  input  logic                rec_empty_i,
  output logic                rec_pop_o,
  output lla_pkg::result_t    res_o,
  output logic                res_push_o,
  input  logic                res_full_i
);

  function automatic logic rule_lookup(input logic [8:0] win, input lla_pkg::rule_t rule);
    logic [3:0] cnt;
    cnt = '0;
    for (int b = 0; b < 9; b++) begin
      if (b != 4) begin
        cnt = cnt + 4'(win[b]);
      end
    end
    return win[4] ? rule.survival[cnt] : rule.birth[cnt];
  endfunction

  logic [8:0]        win_q, win_d;
  logic              pend_q, pend_d;
  lla_pkg::result_t  pend_res_q;
  logic [2:0]        newcol;
  logic [8:0]        win_new, win_end;
  logic              has1, has2;
  lla_pkg::result_t  res1, res2;

  always_comb begin
    newcol  = {rec_i.alive, rec_i.cur, rec_i.above};
    win_new = rec_i.col_zero ? {newcol, 6'b000000} : {newcol, win_q[8:3]};
    win_end = {3'b000, win_new[8:3]};
    has1    = ~rec_i.row_zero & ~rec_i.col_zero;
    has2    = rec_i.end_of_row & ~rec_i.row_zero;
    res1.next_alive    = rule_lookup(win_new, rule_i);
    res1.last_of_frame = 1'b0;
    res2.next_alive    = rule_lookup(win_end, rule_i);
    res2.last_of_frame = rec_i.flush;
  end

  always_comb begin
    rec_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = pend_res_q;
    pend_d     = pend_q;
    win_d      = win_q;
    priority if (pend_q) begin
      // The second result of a row-end cell goes out before any later result.
      // A following cell that gives no result is taken in the same cycle.
      res_push_o = ~res_full_i;
      pend_d     = res_full_i;
      if (!res_full_i && !rec_empty_i && !has1 && !has2) begin
        rec_pop_o = 1'b1;
        win_d     = rec_i.end_of_row ? win_end : win_new;
      end
    end else if (!rec_empty_i && !res_full_i) begin
      rec_pop_o  = 1'b1;
      win_d      = rec_i.end_of_row ? win_end : win_new;
      res_push_o = has1 | has2;
      res_o      = has1 ? res1 : res2;
      pend_d     = has1 & has2;
    end else begin
      rec_pop_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      win_q  <= win_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      pend_res_q <= res2;
    end
  end

  `LLA_ASSERT(a_back_pend_from_row_end, clk_i, rst_ni, $rose(pend_q) |-> $past(rec_pop_o && has1 && has2), "second result without a row-end cell")

endmodule

/* sv/life_like_automaton_step_core.sv */
// Top level of the life-like automaton step core: registers, parts and queues.
// Throughput is one cell per cycle while full is low; a row-end cell outside row zero makes
// two result transfers, one per cycle while the output queue has room. A result passes the
// line store read register, the classification queue and output queue; the second result of
// a row-end cell waits in a pending register. Reset clears all control state, then a clearing
// pass zeroes the line store with full held high; configuration writes are taken throughout.
module life_like_automaton_step_core #(
  parameter int unsigned MAX_WIDTH  = lla_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = lla_pkg::MaxHeightDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  logic                       mode_i,
  input  logic                       cell_alive_i,
  output logic                       full,
  output logic                       empty,
  input  logic                       pop,
  output logic                       next_alive_o,
  output logic                       last_of_frame_o,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [lla_pkg::MaskW-1:0]  cfg_wdata_i
);

  // Configuration registers. Writes must land only while the core is idle; the core does not
  // enforce this, and the parts read them directly without any shadowing.
  logic [lla_pkg::MaskW-1:0] birth_mask_q;
  logic [lla_pkg::MaskW-1:0] survival_mask_q;
  logic [lla_pkg::DimW-1:0]  grid_width_q;
  logic [lla_pkg::DimW-1:0]  grid_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_mask_q    <= lla_pkg::BirthMaskRst;
      survival_mask_q <= lla_pkg::SurvivalMaskRst;
      grid_width_q    <= lla_pkg::GridWidthRst;
      grid_height_q   <= lla_pkg::GridHeightRst;
    end else if (cfg_we_i) begin
      unique case (lla_pkg::cfg_reg_e'(cfg_idx_i))
        lla_pkg::RegBirthMask:    birth_mask_q    <= cfg_wdata_i;
        lla_pkg::RegSurvivalMask: survival_mask_q <= cfg_wdata_i;
        lla_pkg::RegGridWidth:    grid_width_q    <= cfg_wdata_i[lla_pkg::DimW-1:0];
        lla_pkg::RegGridHeight:   grid_height_q   <= cfg_wdata_i[lla_pkg::DimW-1:0];
        default: begin
        end
      endcase
    end
  end

  lla_pkg::rule_t rule;
  assign rule.birth    = birth_mask_q;
  assign rule.survival = survival_mask_q;

  // The front part tracks the raster position, reads and rewrites the two
  // line stores (kept as one two-bit-wide memory) and emits one classified
  // record per cell into a short queue.
  lla_pkg::cell_rec_t mid_in, mid_out;
  logic               mid_push, mid_full, mid_pop, mid_empty;

  lla_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .mode_i        (mode_i),
    .cell_alive_i  (cell_alive_i),
    .full_o        (full),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .rec_o         (mid_in),
    .rec_push_o    (mid_push),
    .rec_full_i    (mid_full)
  );

  lla_fifo #(
    .Width ($bits(lla_pkg::cell_rec_t)),
    .Depth (lla_pkg::QueueDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  // The back part slides the 3x3 window, applies the birth or survival rule
  // and holds the second result of a row-end cell outside row zero in a pending
  // register. A following cell that gives no result is taken while that result goes
  // out, so the back part keeps pace with one cell per cycle while the output queue has room.
  lla_pkg::result_t res_in, res_out;
  logic             res_push, res_full;

  lla_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rule_i      (rule),
    .rec_i       (mid_out),
    .rec_empty_i (mid_empty),
    .rec_pop_o   (mid_pop),
    .res_o       (res_in),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // The output queue decouples result transfers from the back part, so new
  // cells keep flowing while a finished result waits to be popped and the queue has room.
  lla_fifo #(
    .Width ($bits(lla_pkg::result_t)),
    .Depth (lla_pkg::QueueDepth)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign next_alive_o    = res_out.next_alive;
  assign last_of_frame_o = res_out.last_of_frame;

endmodule
